// ===== design/tdpt_pkg.sv =====
// Shared constants for the trial-division primality tester.
`timescale 1ns / 1ps

package tdpt_pkg;

   localparam int NUMBER_BITS_DEFAULT = 31;
   localparam int FIRST_TRIAL         = 2;

endpackage

// ===== design/tdpt_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by all trial divisors.
`timescale 1ns / 1ps

module tdpt_divider import tdpt_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] dividend,
   input  logic [NUMBER_BITS-1:0] divisor,
   output logic                   done,
   output logic [NUMBER_BITS-1:0] quotient,
   output logic [NUMBER_BITS-1:0] remainder
);

   localparam int CW = $clog2(NUMBER_BITS + 1);

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] divisor_ff, divisor_in;
   logic [NUMBER_BITS:0]   shifted;
   logic [NUMBER_BITS:0]   diff;

   assign shifted = {rem_ff, quo_ff[NUMBER_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      active_in  = active_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         active_in  = 1'b1;
         count_in   = CW'(NUMBER_BITS);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (active_ff) begin
         count_in = count_ff - CW'(1);
         if (!diff[NUMBER_BITS]) begin
            rem_in = diff[NUMBER_BITS-1:0];
            quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[NUMBER_BITS-1:0];
            quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b0};
         end
         if (count_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("divider started while active");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff && divisor_ff != '0 |-> rem_ff < divisor_ff)
      else $error("remainder not below divisor");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

endmodule

// ===== design/trial_division_prime_test.sv =====
// Top level: trial-division primality test, sequencer around one shared divider.
// Inputs 0..2 are answered from the idle state without the divider; larger inputs
// alternate check and divide states until a trial divides or passes the bound; about
// 46341 divisors worst case at 31 bits.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Each trial divisor takes a full division plus a pass through the check state.
// Reset is synchronous, active high, and returns the sequencer to idle; the
// result strobe cannot be stalled by the receiver.
`timescale 1ns / 1ps

module trial_division_prime_test import tdpt_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   output logic                   rsp_prime
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [NUMBER_BITS-1:0] number_ff, number_in;
   logic [NUMBER_BITS-1:0] trial_ff, trial_in;
   logic [NUMBER_BITS-1:0] bound_ff, bound_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;
   logic                   div_start;
   logic                   div_done;
   logic [NUMBER_BITS-1:0] div_quotient;
   logic [NUMBER_BITS-1:0] div_remainder;

   tdpt_divider #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number_ff),
      .divisor   (trial_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign div_start = (state_ff == ST_CHECK) && (trial_ff <= bound_ff);

   always_comb begin
      state_in     = state_ff;
      number_in    = number_ff;
      trial_in     = trial_ff;
      bound_in     = bound_ff;
      rsp_valid_in = 1'b0;
      rsp_prime_in = rsp_prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               number_in = req_number;
               trial_in  = NUMBER_BITS'(FIRST_TRIAL);
               bound_in  = req_number;
               if (req_number < NUMBER_BITS'(FIRST_TRIAL)) begin
                  rsp_valid_in = 1'b1;
                  rsp_prime_in = 1'b0;
               end else if (req_number == NUMBER_BITS'(FIRST_TRIAL)) begin
                  rsp_valid_in = 1'b1;
                  rsp_prime_in = 1'b1;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (trial_ff > bound_ff) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_prime_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  bound_in = div_quotient;
                  trial_in = trial_ff + NUMBER_BITS'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      number_ff    <= number_in;
      trial_ff     <= trial_in;
      bound_ff     <= bound_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = rsp_prime_ff;

   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_number < NUMBER_BITS'(FIRST_TRIAL)
      |=> rsp_valid && !rsp_prime)
      else $error("zero or one reported prime");

   a_done_only_dividing: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider result outside divide state");

   a_trial_floor: assert property (@(posedge clock) disable iff (reset)
      busy |-> trial_ff >= NUMBER_BITS'(FIRST_TRIAL))
      else $error("trial divisor below two");

   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("transaction ended without a result");

endmodule
